// ----- rtl/core/tlpq_pkg.sv -----
// Shared types and constants of the three-level priority queue.
package tlpq_pkg;

    // Fixed field widths
    localparam int ITEM_BITS      = 8;
    localparam int BOUND_BITS     = 8;
    localparam int END_BITS       = 9;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 9;
    localparam int LEVEL_BITS     = 2;
    localparam int STATUS_BITS    = 3;
    localparam int NUM_LEVELS     = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_START   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEDIUM_START = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_START    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_END      = 3'd3;

    // Band bounds after reset
    localparam logic [BOUND_BITS-1:0] RESET_HIGH_START   = 8'd10;
    localparam logic [BOUND_BITS-1:0] RESET_MEDIUM_START = 8'd20;
    localparam logic [BOUND_BITS-1:0] RESET_LOW_START    = 8'd30;
    localparam logic [END_BITS-1:0]   RESET_LOW_END      = 9'd40;

    // Request actions
    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_REMOVE = 1'b1;

    // Queue levels
    localparam logic [LEVEL_BITS-1:0] LEVEL_HIGH   = 2'd0;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MEDIUM = 2'd1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_LOW    = 2'd2;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_INSERTED    = 3'd0,
        STATUS_OUT_OF_BAND = 3'd1,
        STATUS_FULL        = 3'd2,
        STATUS_REMOVED     = 3'd3,
        STATUS_EMPTY       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DROP   = 2'd2
    } cmd_kind_t;

    // Classified command from front to back
    typedef struct packed {
        cmd_kind_t              kind;
        logic [LEVEL_BITS-1:0]  level;
        logic [ITEM_BITS-1:0]   value;
    } cmd_t;

    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_READ = 1'b1
    } back_state_t;

endpackage

// ----- rtl/core/tlpq_if.sv -----
// Request and response channel interfaces of the three-level priority queue.
interface tlpq_req_if
    import tlpq_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [ITEM_BITS-1:0] item_value;

    modport source (output valid, action, item_value, input ready);
    modport sink   (input valid, action, item_value, output ready);
endinterface

interface tlpq_rsp_if
    import tlpq_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ITEM_BITS-1:0]   served_value;
    logic [LEVEL_BITS-1:0]  served_level;

    modport source (output valid, status, served_value, served_level, input ready);
    modport sink   (input valid, status, served_value, served_level, output ready);
endinterface

// ----- rtl/core/tlpq_front.sv -----
// Front end: band registers and request classification.
module tlpq_front
    import tlpq_pkg::*;
#(
    parameter int VALUE_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      action,
    input  logic [ITEM_BITS-1:0]      item_value,
    output cmd_t                      cmd
);

    localparam int KeepBits = (VALUE_BITS < ITEM_BITS) ? VALUE_BITS : ITEM_BITS;

    logic [BOUND_BITS-1:0] high_start_reg;
    logic [BOUND_BITS-1:0] medium_start_reg;
    logic [BOUND_BITS-1:0] low_start_reg;
    logic [END_BITS-1:0]   low_end_reg;

    logic [ITEM_BITS-1:0]  value_masked;
    logic [END_BITS-1:0]   value_ext;
    logic                  hit_high;
    logic                  hit_medium;
    logic                  hit_low;

    // Band bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_start_reg   <= RESET_HIGH_START;
            medium_start_reg <= RESET_MEDIUM_START;
            low_start_reg    <= RESET_LOW_START;
            low_end_reg      <= RESET_LOW_END;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HIGH_START:   high_start_reg   <= cfg_data[BOUND_BITS-1:0];
                REG_MEDIUM_START: medium_start_reg <= cfg_data[BOUND_BITS-1:0];
                REG_LOW_START:    low_start_reg    <= cfg_data[BOUND_BITS-1:0];
                REG_LOW_END:      low_end_reg      <= cfg_data[END_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Band compares; an empty or reversed band never matches
    assign value_masked = ITEM_BITS'(KeepBits'(item_value));
    assign value_ext    = END_BITS'(value_masked);
    assign hit_high     = (value_ext >= END_BITS'(high_start_reg)) &&
                          (value_ext <  END_BITS'(medium_start_reg));
    assign hit_medium   = (value_ext >= END_BITS'(medium_start_reg)) &&
                          (value_ext <  END_BITS'(low_start_reg));
    assign hit_low      = (value_ext >= END_BITS'(low_start_reg)) &&
                          (value_ext <  low_end_reg);

    // Command build, highest band wins on overlap
    always_comb
    begin
        cmd.value = value_masked;
        cmd.level = LEVEL_HIGH;
        cmd.kind  = CMD_DROP;
        if (action == ACTION_REMOVE)
        begin
            cmd.kind = CMD_REMOVE;
        end
        else if (hit_high)
        begin
            cmd.kind = CMD_INSERT;
        end
        else if (hit_medium)
        begin
            cmd.kind  = CMD_INSERT;
            cmd.level = LEVEL_MEDIUM;
        end
        else if (hit_low)
        begin
            cmd.kind  = CMD_INSERT;
            cmd.level = LEVEL_LOW;
        end
    end

endmodule

// ----- rtl/core/tlpq_cmd_fifo.sv -----
// Two-entry command queue between the front and back ends.
module tlpq_cmd_fifo
    import tlpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic not_empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/tlpq_back.sv -----
// Back end: three queue memories, pointers, counts and the response register.
module tlpq_back
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_BITS  = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  cmd_t                    cmd,
    output logic                    cmd_pop,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic [STATUS_BITS-1:0]  rsp_status,
    output logic [ITEM_BITS-1:0]    rsp_value,
    output logic [LEVEL_BITS-1:0]   rsp_level
);

    localparam int KeepBits = (VALUE_BITS < ITEM_BITS) ? VALUE_BITS : ITEM_BITS;
    localparam int AddrBits = $clog2(QUEUE_DEPTH);
    localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AddrBits-1:0]  LastAddr = AddrBits'(QUEUE_DEPTH - 1);
    localparam logic [CountBits-1:0] FullCount = CountBits'(QUEUE_DEPTH);

    back_state_t state_reg;
    back_state_t state_next;

    logic [KeepBits-1:0]  mem [NUM_LEVELS][QUEUE_DEPTH];
    logic [KeepBits-1:0]  rd_data_reg [NUM_LEVELS];
    logic [AddrBits-1:0]  rd_ptr_reg [NUM_LEVELS];
    logic [AddrBits-1:0]  wr_ptr_reg [NUM_LEVELS];
    logic [CountBits-1:0] count_reg [NUM_LEVELS];

    logic [LEVEL_BITS-1:0] serve_level_reg;
    logic [LEVEL_BITS-1:0] serve_level_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [ITEM_BITS-1:0]   out_value_reg;
    logic [LEVEL_BITS-1:0]  out_level_reg;

    logic [NUM_LEVELS-1:0]  nonempty;
    logic                   any_data;
    logic [LEVEL_BITS-1:0]  pick_level;
    logic                   sel_full;
    logic                   exec;
    logic                   do_insert;
    logic                   do_remove;
    logic [NUM_LEVELS-1:0]  ins_hit;
    logic [NUM_LEVELS-1:0]  rem_hit;
    logic                   load;
    status_t                load_status;
    logic [ITEM_BITS-1:0]   load_value;
    logic [LEVEL_BITS-1:0]  load_level;
    logic [KeepBits-1:0]    read_word;

    // Queue occupancy and priority pick
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
        any_data = |nonempty;
        if (nonempty[0])
        begin
            pick_level = LEVEL_HIGH;
        end
        else if (nonempty[1])
        begin
            pick_level = LEVEL_MEDIUM;
        end
        else
        begin
            pick_level = LEVEL_LOW;
        end
    end

    // Full flag of the addressed queue
    always_comb
    begin
        case (cmd.level)
            LEVEL_HIGH:   sel_full = (count_reg[0] == FullCount);
            LEVEL_MEDIUM: sel_full = (count_reg[1] == FullCount);
            LEVEL_LOW:    sel_full = (count_reg[2] == FullCount);
            default:      sel_full = 1'b1;
        endcase
    end

    // Read word of the queue being served
    always_comb
    begin
        case (serve_level_reg)
            LEVEL_HIGH:   read_word = rd_data_reg[0];
            LEVEL_MEDIUM: read_word = rd_data_reg[1];
            default:      read_word = rd_data_reg[2];
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_EXEC:
            begin
                if (exec && (cmd.kind == CMD_REMOVE) && any_data)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_EXEC;
            end
            default:
            begin
                state_next = BK_EXEC;
            end
        endcase
    end

    // Command execution and response load
    always_comb
    begin
        exec             = 1'b0;
        do_insert        = 1'b0;
        do_remove        = 1'b0;
        load             = 1'b0;
        load_status      = STATUS_INSERTED;
        load_value       = '0;
        load_level       = LEVEL_HIGH;
        serve_level_next = serve_level_reg;
        case (state_reg)
            BK_EXEC:
            begin
                exec = cmd_valid && (!out_valid_reg || rsp_ready);
                if (exec)
                begin
                    case (cmd.kind)
                        CMD_INSERT:
                        begin
                            load       = 1'b1;
                            load_level = cmd.level;
                            if (sel_full)
                            begin
                                load_status = STATUS_FULL;
                            end
                            else
                            begin
                                do_insert   = 1'b1;
                                load_status = STATUS_INSERTED;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (any_data)
                            begin
                                do_remove        = 1'b1;
                                serve_level_next = pick_level;
                            end
                            else
                            begin
                                load        = 1'b1;
                                load_status = STATUS_EMPTY;
                            end
                        end
                        default:
                        begin
                            load        = 1'b1;
                            load_status = STATUS_OUT_OF_BAND;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                load        = 1'b1;
                load_status = STATUS_REMOVED;
                load_value  = ITEM_BITS'(read_word);
                load_level  = serve_level_reg;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            ins_hit[i] = do_insert && (cmd.level == LEVEL_BITS'(i));
            rem_hit[i] = do_remove && (pick_level == LEVEL_BITS'(i));
        end
    end

    assign cmd_pop = exec;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                if (ins_hit[i])
                begin
                    wr_ptr_reg[i] <= (wr_ptr_reg[i] == LastAddr) ? '0 : wr_ptr_reg[i] + 1'b1;
                    count_reg[i]  <= count_reg[i] + 1'b1;
                end
                if (rem_hit[i])
                begin
                    rd_ptr_reg[i] <= (rd_ptr_reg[i] == LastAddr) ? '0 : rd_ptr_reg[i] + 1'b1;
                    count_reg[i]  <= count_reg[i] - 1'b1;
                end
            end
        end
    end

    // Response payload and served level
    always_ff @(posedge clk)
    begin
        serve_level_reg <= serve_level_next;
        if (load)
        begin
            out_status_reg <= load_status;
            out_value_reg  <= load_value;
            out_level_reg  <= load_level;
        end
    end

    // Queue memories: one write and one registered read per queue
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (ins_hit[i])
            begin
                mem[i][wr_ptr_reg[i]] <= KeepBits'(cmd.value);
            end
            if (rem_hit[i])
            begin
                rd_data_reg[i] <= mem[i][rd_ptr_reg[i]];
            end
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_value  = out_value_reg;
    assign rsp_level  = out_level_reg;

endmodule

// ----- rtl/core/three_level_priority_queue_core.sv -----
// Top level of the three-level priority queue.
//
// Requests come in on the request channel: action 0 inserts item_value, action 1
// removes the oldest entry of the highest non-empty queue. Each request yields one
// beat on the response channel with status, served_value and served_level.
// Inserts are sorted into the high, medium or low queue by four band registers
// written through cfg_we / cfg_index / cfg_data; the user must write them only
// while the block is idle, and the block itself does not enforce it. A front
// end classifies each request and pushes it into a two-entry command queue; a
// back end executes commands against three QUEUE_DEPTH-entry memories. Each
// request passes the command queue and the response register; a remove that
// serves an entry also waits for the registered memory read, which keeps the
// back end from its next command; otherwise it takes one request per cycle
// while the receiver takes responses. Reset clears all queues to empty and
// loads bands 10-19, 20-29 and 30-39; the memories need no clearing. When the
// receiver stalls, the response register holds its beat, the command queue
// fills and request ready drops as soon as both command queue entries are taken.
module three_level_priority_queue_core
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_BITS  = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    tlpq_req_if.sink                  request,
    tlpq_rsp_if.source                response
);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic fifo_full;
    logic fifo_not_empty;
    logic back_pop;
    logic req_beat;

    assign request.ready = !fifo_full;
    assign req_beat      = request.valid && !fifo_full;

    tlpq_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .action     (request.action),
        .item_value (request.item_value),
        .cmd        (front_cmd)
    );

    tlpq_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_beat),
        .push_cmd  (front_cmd),
        .full      (fifo_full),
        .pop       (back_pop),
        .pop_cmd   (back_cmd),
        .not_empty (fifo_not_empty)
    );

    tlpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (fifo_not_empty),
        .cmd        (back_cmd),
        .cmd_pop    (back_pop),
        .rsp_valid  (response.valid),
        .rsp_ready  (response.ready),
        .rsp_status (response.status),
        .rsp_value  (response.served_value),
        .rsp_level  (response.served_level)
    );

endmodule

// ----- rtl/core/tlpq_checker.sv -----
// Port-level checks of the three-level priority queue, bound to the top level.
module tlpq_checker
    import tlpq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [STATUS_BITS-1:0] rsp_status,
    input logic [ITEM_BITS-1:0]   rsp_value,
    input logic [LEVEL_BITS-1:0]  rsp_level
);

    // A stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_value) && $stable(rsp_level))
    else $error("stalled response beat changed");

    // Only a served entry carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STATUS_REMOVED) |-> rsp_value == '0)
    else $error("value on a response that serves nothing");

    // Drops and empty removes name the high queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == STATUS_OUT_OF_BAND) || (rsp_status == STATUS_EMPTY))
        |-> rsp_level == LEVEL_HIGH)
    else $error("queue level on a drop or empty remove");

    // Status and level codes stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status <= STATUS_EMPTY) && (rsp_level <= LEVEL_LOW))
    else $error("response code out of range");

endmodule

bind three_level_priority_queue_core tlpq_checker u_tlpq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (response.valid),
    .rsp_ready  (response.ready),
    .rsp_status (response.status),
    .rsp_value  (response.served_value),
    .rsp_level  (response.served_level)
);

// ----- verif/tb_three_level_priority_queue_core.sv -----
// Self-checking testbench of the three-level priority queue core.
module tb_three_level_priority_queue_core
    import tlpq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int POS_BITS     = $clog2(QUEUE_DEPTH);
    localparam int SEGMENTS     = 7;
    localparam int SEG_ITEMS    = 140;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;

    // Indexes that map to no register
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_FIRST = REG_LOW_END + 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LAST  = 3'd7;

    typedef struct packed {
        logic                 action;
        logic [ITEM_BITS-1:0] value;
    } request_t;

    typedef struct packed {
        status_t               status;
        logic [ITEM_BITS-1:0]  value;
        logic [LEVEL_BITS-1:0] level;
    } outcome_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    tlpq_req_if request_ch ();
    tlpq_rsp_if response_ch ();

    three_level_priority_queue_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .response  (response_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the band registers and the three queues
    logic [BOUND_BITS-1:0] band_high_start   = RESET_HIGH_START;
    logic [BOUND_BITS-1:0] band_medium_start = RESET_MEDIUM_START;
    logic [BOUND_BITS-1:0] band_low_start    = RESET_LOW_START;
    logic [END_BITS-1:0]   band_low_end      = RESET_LOW_END;
    logic [ITEM_BITS-1:0]  queue_mem  [NUM_LEVELS][QUEUE_DEPTH];
    logic [POS_BITS-1:0]   head_pos   [NUM_LEVELS] = '{default: '0};
    logic [POS_BITS-1:0]   tail_pos   [NUM_LEVELS] = '{default: '0};
    logic [POS_BITS:0]     fill_count [NUM_LEVELS] = '{default: '0};

    request_t pending_requests[$];
    outcome_t pending_outcomes[$];

    int  issued         = 0;
    int  beats_seen     = 0;
    int  mismatches     = 0;
    int  send_idle_pct  = 33;
    int  recv_stall_pct = 71;
    int  status_tally [8] = '{default: 0};
    int  served_tally [NUM_LEVELS] = '{default: 0};
    bit  req_took       = 1'b0;

    // Apply one request to the shadow queues and return the outcome it yields
    function automatic outcome_t queue_step(request_t rq);
        outcome_t o;
        int       lvl;
        o   = '{STATUS_INSERTED, '0, LEVEL_HIGH};
        lvl = -1;
        if (rq.action == ACTION_INSERT)
        begin
            // highest-ranked matching band wins
            if (rq.value >= band_high_start && rq.value < band_medium_start)
                lvl = LEVEL_HIGH;
            else if (rq.value >= band_medium_start && rq.value < band_low_start)
                lvl = LEVEL_MEDIUM;
            else if (rq.value >= band_low_start && rq.value < band_low_end)
                lvl = LEVEL_LOW;
            if (lvl < 0)
                o.status = STATUS_OUT_OF_BAND;
            else if (fill_count[lvl] == QUEUE_DEPTH)
            begin
                o.status = STATUS_FULL;
                o.level  = LEVEL_BITS'(lvl);
            end
            else
            begin
                queue_mem[lvl][tail_pos[lvl]] = rq.value;
                tail_pos[lvl]   = tail_pos[lvl] + 1'b1;
                fill_count[lvl] = fill_count[lvl] + 1'b1;
                o.level         = LEVEL_BITS'(lvl);
            end
        end
        else
        begin
            o.status = STATUS_EMPTY;
            for (int q = 0; q < NUM_LEVELS; q++)
            begin
                if (lvl < 0 && fill_count[q] != 0)
                begin
                    lvl           = q;
                    o.status      = STATUS_REMOVED;
                    o.value       = queue_mem[q][head_pos[q]];
                    o.level       = LEVEL_BITS'(q);
                    head_pos[q]   = head_pos[q] + 1'b1;
                    fill_count[q] = fill_count[q] - 1'b1;
                    served_tally[q]++;
                end
            end
        end
        status_tally[o.status]++;
        return o;
    endfunction

    // Random value inside one band, or anywhere when that band is empty
    function automatic logic [ITEM_BITS-1:0] pick_band_value(int lvl);
        int lo;
        int hi;
        case (lvl)
            LEVEL_HIGH:
            begin
                lo = band_high_start;
                hi = band_medium_start;
            end
            LEVEL_MEDIUM:
            begin
                lo = band_medium_start;
                hi = band_low_start;
            end
            default:
            begin
                lo = band_low_start;
                hi = band_low_end;
            end
        endcase
        if (lo < hi)
            return ITEM_BITS'($urandom_range(hi - 1, lo));
        return ITEM_BITS'($urandom_range(255, 0));
    endfunction

    task automatic enqueue(logic action, logic [ITEM_BITS-1:0] value);
        pending_requests.push_back('{action, value});
        issued++;
    endtask

    // Register write; the shadow copy follows with the same masking
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index,
                             logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            REG_HIGH_START:   band_high_start   = data[BOUND_BITS-1:0];
            REG_MEDIUM_START: band_medium_start = data[BOUND_BITS-1:0];
            REG_LOW_START:    band_low_start    = data[BOUND_BITS-1:0];
            REG_LOW_END:      band_low_end      = data[END_BITS-1:0];
            default:          ;
        endcase
    endtask

    // Wait for every response, then let the pipeline settle
    task automatic wait_drained();
        while (beats_seen < issued)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly insert bursts into one band followed by remove bursts, some noise
    task automatic fill_segment(int count);
        int made;
        int lvl;
        int burst;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(9, 0) < 7)
            begin
                lvl   = $urandom_range(2, 0);
                burst = $urandom_range(20, 1);
                repeat (burst)
                begin
                    if ($urandom_range(5, 0) == 0)
                        enqueue(ACTION_INSERT, pick_band_value($urandom_range(2, 0)));
                    else
                        enqueue(ACTION_INSERT, pick_band_value(lvl));
                    made++;
                end
                burst = $urandom_range(20, 1);
                repeat (burst)
                begin
                    enqueue(ACTION_REMOVE, ITEM_BITS'($urandom_range(255, 0)));
                    made++;
                end
            end
            else
            begin
                enqueue(1'($urandom_range(1, 0)), ITEM_BITS'($urandom_range(255, 0)));
                made++;
            end
        end
    endtask

    // Request driver and response back-pressure, both on the falling edge
    always @(negedge clk)
    begin
        request_t next_rq;
        if (rst_n && (!request_ch.valid || req_took))
        begin
            if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                next_rq = pending_requests.pop_front();
                request_ch.valid      <= 1'b1;
                request_ch.action     <= next_rq.action;
                request_ch.item_value <= next_rq.value;
            end
            else
                request_ch.valid <= 1'b0;
        end
        response_ch.ready <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Monitor: check response beats, then predict for accepted requests
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            req_took <= request_ch.valid && request_ch.ready;
            if (response_ch.valid && response_ch.ready)
            begin
                beats_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: response beat with nothing pending: status %0d value %0d level %0d",
                                 $realtime, response_ch.status, response_ch.served_value,
                                 response_ch.served_level);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (response_ch.status !== want.status
                        || response_ch.served_value !== want.value
                        || response_ch.served_level !== want.level)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: beat %0d wanted status %0d value %0d level %0d, got %0d %0d %0d",
                                     $realtime, beats_seen, want.status, want.value, want.level,
                                     response_ch.status, response_ch.served_value,
                                     response_ch.served_level);
                    end
                end
            end
            if (request_ch.valid && request_ch.ready)
                pending_outcomes.push_back(queue_step('{request_ch.action,
                                                        request_ch.item_value}));
        end
    end

    // Stimulus sequence
    initial
    begin
        logic [CFG_DATA_BITS-1:0] band_plan [SEGMENTS][4];
        band_plan = '{
            '{9'd10,  9'd20,  9'd30,  9'd40 },   // reset bands
            '{9'h100, 9'd128, 9'd200, 9'd256},   // widest spread, bit 8 masked off
            '{9'd50,  9'd40,  9'd100, 9'd255},   // reversed high band
            '{9'd10,  9'd100, 9'd50,  9'd200},   // low band overlaps high band
            '{9'h1FF, 9'hFF,  9'hFF,  9'd256},   // only 255 lands, in the low queue
            '{9'd0,   9'd0,   9'd0,   9'd0  },   // random bounds, filled in below
            '{9'd0,   9'd0,   9'd0,   9'd0  }    // every band empty
        };

        request_ch.valid      = 1'b0;
        request_ch.action     = ACTION_INSERT;
        request_ch.item_value = '0;
        response_ch.ready     = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_HIGH_START;
        cfg_data              = '0;
        rst_n                 = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty remove, band edges, priority order, drain to empty
        enqueue(ACTION_REMOVE, 8'd0);
        enqueue(ACTION_INSERT, 8'd0);
        enqueue(ACTION_INSERT, 8'd255);
        enqueue(ACTION_INSERT, 8'd9);
        enqueue(ACTION_INSERT, 8'd39);
        enqueue(ACTION_INSERT, 8'd30);
        enqueue(ACTION_INSERT, 8'd29);
        enqueue(ACTION_INSERT, 8'd20);
        enqueue(ACTION_INSERT, 8'd19);
        enqueue(ACTION_INSERT, 8'd10);
        enqueue(ACTION_INSERT, 8'd40);
        repeat (6) enqueue(ACTION_REMOVE, 8'd255);
        enqueue(ACTION_REMOVE, 8'd170);
        enqueue(ACTION_INSERT, 8'd35);
        enqueue(ACTION_INSERT, 8'd15);
        enqueue(ACTION_REMOVE, 8'd85);
        enqueue(ACTION_REMOVE, 8'd0);
        wait_drained();

        // Random segments, one band setting each
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct  = (seg * 3 / SEGMENTS == 0) ? 33 : (seg * 3 / SEGMENTS == 1) ? 71 : 0;
            recv_stall_pct = (seg * 3 / SEGMENTS == 0) ? 71 : (seg * 3 / SEGMENTS == 1) ? 33 : 0;
            if (seg == 5)
            begin
                band_plan[seg][0] = CFG_DATA_BITS'($urandom_range(511, 0));
                band_plan[seg][1] = CFG_DATA_BITS'($urandom_range(511, 0));
                band_plan[seg][2] = CFG_DATA_BITS'($urandom_range(511, 0));
                band_plan[seg][3] = CFG_DATA_BITS'($urandom_range(256, 0));
            end
            if (seg != 0)
            begin
                write_reg(REG_HIGH_START,   band_plan[seg][0]);
                write_reg(REG_MEDIUM_START, band_plan[seg][1]);
                write_reg(REG_LOW_START,    band_plan[seg][2]);
                write_reg(REG_LOW_END,      band_plan[seg][3]);
            end
            if (seg == 1)
            begin
                // writes to unmapped indexes must leave the bands alone
                write_reg(REG_UNMAPPED_FIRST, '1);
                write_reg(REG_UNMAPPED_LAST,  '1);
            end
            fill_segment(SEG_ITEMS);
            wait_drained();
        end

        if (pending_outcomes.size() != 0)
        begin
            mismatches++;
            $display("%0d responses never arrived", pending_outcomes.size());
        end
        $display("Ran %0d requests over %0d band settings: %0d inserted, %0d out of band, %0d full",
                 issued, SEGMENTS, status_tally[STATUS_INSERTED],
                 status_tally[STATUS_OUT_OF_BAND], status_tally[STATUS_FULL]);
        $display("Removes: %0d served (high %0d, medium %0d, low %0d), %0d on empty; %0d mismatches",
                 status_tally[STATUS_REMOVED], served_tally[LEVEL_HIGH],
                 served_tally[LEVEL_MEDIUM], served_tally[LEVEL_LOW],
                 status_tally[STATUS_EMPTY], mismatches);
        if (mismatches == 0)
            $display("[three_level_priority_queue_core] OK");
        else
            $display("[three_level_priority_queue_core] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("Timed out with %0d of %0d responses seen", beats_seen, issued);
        $display("[three_level_priority_queue_core] ERROR");
        $finish;
    end

endmodule
